>>> rtl/core/mcst_pkg.sv
// Shared types, constants and helpers of the MIDI channel state tracker.
package mcst_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int NUM_KEYS     = 128;
  localparam int TABLE_DEPTH  = NUM_CHANNELS * NUM_KEYS;
  localparam int ADDR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CHAN_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Command nibbles of channel messages.
  localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
  localparam logic [3:0] CMD_CONTROLLER = 4'hB;
  localparam logic [3:0] CMD_PITCH_BEND = 4'hE;

  // Query kinds as they arrive on the request.
  localparam logic [7:0] QRY_NOTE       = 8'h90;
  localparam logic [7:0] QRY_CONTROLLER = 8'hB0;
  localparam logic [7:0] QRY_PITCH      = 8'hE0;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [7:0] query_command;
    logic [3:0] query_channel;
    logic [6:0] query_key;
  } req_t;

  typedef struct packed {
    logic [13:0] read_value;
    logic [3:0]  event_command;
    logic [3:0]  event_channel;
    logic [6:0]  event_first;
    logic [6:0]  event_second;
  } rsp_t;

  function automatic logic chan_ok(input logic [3:0] chan);
    return 32'(chan) < NUM_CHANNELS;
  endfunction

  function automatic logic slot_ok(input logic [3:0] chan, input logic [6:0] key);
    return (32'(chan) < NUM_CHANNELS) && (32'(key) < NUM_KEYS);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [3:0] chan,
                                                  input logic [6:0] key);
    logic [31:0] full;
    full = 32'(chan) * 32'(NUM_KEYS) + 32'(key);
    return full[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/core/mcst_req_if.sv
// Request channel of the MIDI channel state tracker.
interface mcst_req_if;
  logic               valid;
  logic               ready;
  mcst_pkg::req_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/mcst_rsp_if.sv
// Response channel of the MIDI channel state tracker.
interface mcst_rsp_if;
  logic               valid;
  logic               ready;
  mcst_pkg::rsp_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/midi_channel_state_tracker_unit.sv
// Top level of the MIDI channel state tracker: latch, tables and response register.
//
// Usage: requests arrive on req_i, each either a packed MIDI message or a state
// query; every request yields exactly one response on rsp_o. A message updates
// the running-status latch and, for note-on, controller and pitch bend, the
// per-channel tables; its response carries the new latch and a zero value. A
// query reads the note, controller or pitch table and leaves the latch alone.
// A message response is loaded into the response register directly; a query
// response waits on the tables' registered read data first. Messages go one per
// cycle unless the response stalls; a query holds off requests until it is done.
// The response register lets a new request in while it is being taken.
// After reset the two 2048-entry tables are cleared by a sweep that writes one
// entry per cycle, so req_i.ready stays low until the sweep is done; the
// pitch table and latch are cleared at once. A stalled receiver holds the
// response, and req_i.ready stays low until the response register drains.
module midi_channel_state_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcst_req_if.sink    req_i,
  mcst_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_e;

  typedef enum logic [1:0] {
    QK_NONE,
    QK_NOTE,
    QK_CONTROLLER,
    QK_PITCH
  } qkind_e;

  state_e state_q;
  logic [mcst_pkg::ADDR_W-1:0] clr_cnt_q;

  logic [3:0] lat_cmd_q, lat_cmd_d;
  logic [3:0] lat_chan_q, lat_chan_d;
  logic [6:0] lat_first_q, lat_first_d;
  logic [6:0] lat_second_q, lat_second_d;

  logic [13:0] pitch_q [mcst_pkg::NUM_CHANNELS];

  logic [6:0] note_mem [mcst_pkg::TABLE_DEPTH];
  logic [6:0] ctrl_mem [mcst_pkg::TABLE_DEPTH];
  logic [6:0] note_rd_q, ctrl_rd_q;

  qkind_e      qkind_q;
  logic        qok_q;
  logic [13:0] pitch_rd_q;

  logic           rsp_valid_q, rsp_valid_d;
  mcst_pkg::rsp_t rsp_q;

  logic                        accept, msg_acc, qry_acc;
  logic                        note_we, ctrl_we, pitch_we, slot_hit;
  logic [mcst_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [6:0]                  wr_data;
  qkind_e                      qkind_d;
  logic [13:0]                 qry_value;

  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign msg_acc     = accept && (req_i.data.op == mcst_pkg::OP_MESSAGE);
  assign qry_acc     = accept && (req_i.data.op == mcst_pkg::OP_QUERY);

  // A status byte loads the whole latch; running status keeps command and channel and shifts the data bytes down.
  always_comb begin
    lat_cmd_d    = lat_cmd_q;
    lat_chan_d   = lat_chan_q;
    lat_first_d  = lat_first_q;
    lat_second_d = lat_second_q;
    if (req_i.data.status_byte[7]) begin
      lat_cmd_d    = req_i.data.status_byte[7:4];
      lat_chan_d   = req_i.data.status_byte[3:0];
      lat_first_d  = req_i.data.data_first;
      lat_second_d = req_i.data.data_second;
    end else begin
      lat_first_d  = req_i.data.status_byte[6:0];
      lat_second_d = req_i.data.data_first;
    end
  end

  assign slot_hit = mcst_pkg::slot_ok(lat_chan_d, lat_first_d);
  assign note_we  = msg_acc && (lat_cmd_d == mcst_pkg::CMD_NOTE_ON) && slot_hit;
  assign ctrl_we  = msg_acc && (lat_cmd_d == mcst_pkg::CMD_CONTROLLER) && slot_hit;
  assign pitch_we = msg_acc && (lat_cmd_d == mcst_pkg::CMD_PITCH_BEND)
                    && mcst_pkg::chan_ok(lat_chan_d);

  assign wr_addr = (state_q == ST_CLEAR) ? clr_cnt_q
                                         : mcst_pkg::slot_addr(lat_chan_d, lat_first_d);
  assign wr_data = (state_q == ST_CLEAR) ? 7'd0 : lat_second_d;
  assign rd_addr = mcst_pkg::slot_addr(req_i.data.query_channel, req_i.data.query_key);

  always_comb begin
    case (req_i.data.query_command)
      mcst_pkg::QRY_NOTE:       qkind_d = QK_NOTE;
      mcst_pkg::QRY_CONTROLLER: qkind_d = QK_CONTROLLER;
      mcst_pkg::QRY_PITCH:      qkind_d = QK_PITCH;
      default:                  qkind_d = QK_NONE;
    endcase
  end

  always_comb begin
    case (qkind_q)
      QK_NOTE:       qry_value = qok_q ? {7'd0, note_rd_q} : 14'd0;
      QK_CONTROLLER: qry_value = qok_q ? {7'd0, ctrl_rd_q} : 14'd0;
      QK_PITCH:      qry_value = qok_q ? pitch_rd_q : 14'd0;
      default:       qry_value = 14'd0;
    endcase
  end

  // The response register is loaded by a message or by the end of a table read.
  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    if (msg_acc || (state_q == ST_READ)) begin
      rsp_valid_d = 1'b1;
    end
  end

  // Table memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (note_we || (state_q == ST_CLEAR)) begin
      note_mem[wr_addr] <= wr_data;
    end
    if (ctrl_we || (state_q == ST_CLEAR)) begin
      ctrl_mem[wr_addr] <= wr_data;
    end
    if (qry_acc) begin
      note_rd_q <= note_mem[rd_addr];
      ctrl_rd_q <= ctrl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mcst_pkg::NUM_CHANNELS; i++) begin
        pitch_q[i] <= 14'd0;
      end
    end else if (pitch_we) begin
      pitch_q[lat_chan_d[mcst_pkg::CHAN_IDX_W-1:0]] <= {lat_second_d, lat_first_d};
    end
  end

  // Query side data; the memory read completes in ST_READ.
  always_ff @(posedge clk_i) begin
    if (qry_acc) begin
      qkind_q <= qkind_d;
      if (qkind_d == QK_PITCH) begin
        qok_q <= mcst_pkg::chan_ok(req_i.data.query_channel);
      end else begin
        qok_q <= mcst_pkg::slot_ok(req_i.data.query_channel, req_i.data.query_key);
      end
      pitch_rd_q <= pitch_q[req_i.data.query_channel[mcst_pkg::CHAN_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      lat_cmd_q    <= 4'd0;
      lat_chan_q   <= 4'd0;
      lat_first_q  <= 7'd0;
      lat_second_q <= 7'd0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + mcst_pkg::ADDR_W'(1);
          if (clr_cnt_q == mcst_pkg::ADDR_W'(mcst_pkg::TABLE_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (msg_acc) begin
            lat_cmd_q                <= lat_cmd_d;
            lat_chan_q               <= lat_chan_d;
            lat_first_q              <= lat_first_d;
            lat_second_q             <= lat_second_d;
            rsp_q.read_value         <= 14'd0;
            rsp_q.event_command      <= lat_cmd_d;
            rsp_q.event_channel      <= lat_chan_d;
            rsp_q.event_first        <= lat_first_d;
            rsp_q.event_second       <= lat_second_d;
          end else if (qry_acc) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          rsp_q.read_value         <= qry_value;
          rsp_q.event_command      <= lat_cmd_q;
          rsp_q.event_channel      <= lat_chan_q;
          rsp_q.event_first        <= lat_first_q;
          rsp_q.event_second       <= lat_second_q;
          state_q                  <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule

>>> rtl/core/mcst_checker.sv
// Port-level assertions of the MIDI channel state tracker and their binding.
module mcst_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input mcst_pkg::req_t req_data_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input mcst_pkg::rsp_t rsp_data_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  // A stalled response keeps its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response changed while stalled");

  // A message is answered in the next cycle with a zero value.
  a_msg_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_data_i.op == mcst_pkg::OP_MESSAGE)
      |=> rsp_valid_i && (rsp_data_i.read_value == 14'd0))
    else $error("message response missing or nonzero");

  // A query holds off the next request while the table read is in flight.
  a_qry_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_data_i.op == mcst_pkg::OP_QUERY) |=> !req_ready_i)
    else $error("request taken during a table read");

  // A new response only follows an accepted request.
  a_rsp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_acc) || $past(req_acc, 2))
    else $error("response without a request");

endmodule

bind midi_channel_state_tracker_unit mcst_checker u_mcst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_data_i  (req_i.data),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
